@@ rtl/serial_frame_receiver_crc_check_macros.svh @@
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them away.
`ifndef SERIAL_FRAME_RECEIVER_CRC_CHECK_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CRC_CHECK_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset.
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, held off during reset.
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

  localparam int FRAME_STORE_BYTES = 256;
  localparam int POS_W = $clog2(FRAME_STORE_BYTES);
  // Compare width: covers the position and the payload length plus the trailer offsets.
  localparam int CMP_W = ((POS_W > 8) ? POS_W : 8) + 2;

  localparam logic [7:0] START_BYTE = 8'd2;
  localparam logic [7:0] END_BYTE   = 8'd3;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_POLY  = 1'b0;
  localparam logic REG_START = 1'b1;

  localparam logic [15:0] POLY_RESET  = 16'h1021;
  localparam logic [15:0] START_RESET = 16'h0000;

  typedef enum logic [1:0] {
    DROP_NONE  = 2'd0,
    DROP_START = 2'd1,
    DROP_FRAME = 2'd2
  } drop_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       crc_ok;
    logic [7:0] frame_length;
    drop_t      drop_code;
  } res_t;

  typedef struct packed {
    logic hunting;   // position at zero, waiting for a start byte
  } st_t;

endpackage

@@ rtl/serial_frame_receiver_crc_check.sv @@
// Serial frame receiver with CRC-16 check. Takes one received byte per beat on in_ and
// returns one result beat per input beat on out_, in order. Frames are: start byte 2,
// length byte L, L payload bytes, CRC-16 high byte first, end byte 3. Payload bytes come
// out at once with their index (out_tuser[0] set); the end byte gives out_tlast with the
// length and the CRC match flag. A bad start byte drops the frame with drop code 1; a bad
// end byte or a frame reaching the store size drops it with code 2, and the block hunts
// for the next start byte. The CRC is MSB-first, unreflected, no final XOR; polynomial
// (offset 0x0, reset 0x1021) and start value (offset 0x4, reset 0x0000) are set over the
// cfg_ port; the user must do so only while the block is idle, which the block does not
// enforce. A new start value applies from the next length byte, a new polynomial from the
// next payload byte. Rate: one byte per clock sustained unless out_ stalls; a byte passes
// the input, then the result register. The byte-wide CRC update into the CRC register sets
// the clock limit. Either register may hold a beat while the other side stalls.
`include "serial_frame_receiver_crc_check_macros.svh"

module serial_frame_receiver_crc_check (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] payload_byte, [15:8] payload_index, [16] crc_ok, [24:17] frame_length, rest zero
  output logic [31:0]                    out_tdata,
  output logic [2:0]                     out_tuser,  // [0] payload_valid, [2:1] drop_code
  output logic                           out_tlast,  // frame_done
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic          in_valid_r;
  logic [7:0]    in_data_r;
  logic          out_valid_r;
  sfr_pkg::res_t res_r;
  sfr_pkg::res_t res;
  sfr_pkg::st_t  st;
  logic          step;
  logic          cfg_wr;
  logic [15:0]   poly_r;
  logic [15:0]   start_r;

  // Advance the input register into the result register when the result slot frees up.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Hold the byte while the input register is stalled.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  sfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data      (in_data_r),
    .crc_poly  (poly_r),
    .crc_start (start_r),
    .res       (res),
    .st        (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.frame_length, res_r.crc_ok,
                       res_r.payload_index, res_r.payload_byte};
  assign out_tuser  = {res_r.drop_code, res_r.payload_valid};
  assign out_tlast  = res_r.frame_done;

  // Configuration registers; decode on the word address bit only.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= sfr_pkg::POLY_RESET;
      start_r <= sfr_pkg::START_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        sfr_pkg::REG_POLY:  poly_r  <= cfg_pwdata[15:0];
        sfr_pkg::REG_START: start_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      sfr_pkg::REG_POLY:  cfg_prdata = {16'd0, poly_r};
      sfr_pkg::REG_START: cfg_prdata = {16'd0, start_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // Any drop must send the parser back to hunting for a start byte.
  `SFR_ASSERT_NXT(a_drop_rehunt, clk, rst_n,
    step && (res.drop_code != sfr_pkg::DROP_NONE), st.hunting,
    "drop did not return the parser to hunting")
  // A finished frame returns to hunting too.
  `SFR_ASSERT_NXT(a_done_rehunt, clk, rst_n, step && res.frame_done, st.hunting,
    "frame end did not return the parser to hunting")
  // A result beat is at most one of payload, frame end or drop.
  `SFR_ASSERT_IMP(a_one_kind, clk, rst_n, out_tvalid,
    !(out_tuser[0] && out_tlast) &&
    !((out_tuser[0] || out_tlast) && (out_tuser[2:1] != sfr_pkg::DROP_NONE)),
    "result beat carries more than one kind")
  // Frame end fields stay zero outside a frame end beat.
  `SFR_ASSERT_IMP(a_end_fields, clk, rst_n, out_tvalid && !out_tlast,
    !out_tdata[16] && (out_tdata[24:17] == 8'd0),
    "frame end fields set outside a frame end")

endmodule

@@ rtl/sfr_crc.sv @@
module sfr_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] poly,
  output logic [15:0] crc_out
);

  // MSB-first, one bit per step over the byte.
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

@@ rtl/sfr_parser.sv @@
module sfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data,
  input  logic [15:0]         crc_poly,
  input  logic [15:0]         crc_start,
  output sfr_pkg::res_t       res,
  output sfr_pkg::st_t        st
);

  logic [sfr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  rx_hi_r, rx_hi_nxt;
  logic [7:0]  rx_lo_r, rx_lo_nxt;
  logic [15:0] crc_upd;
  logic [sfr_pkg::CMP_W-1:0] pos_ext, len_ext;

  sfr_crc u_crc (
    .crc_in  (crc_r),
    .data    (data),
    .poly    (crc_poly),
    .crc_out (crc_upd)
  );

  assign pos_ext = sfr_pkg::CMP_W'(pos_r);
  assign len_ext = sfr_pkg::CMP_W'(len_r);

  always_comb begin
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    rx_hi_nxt = rx_hi_r;
    rx_lo_nxt = rx_lo_r;
    res       = '0;
    res.drop_code = sfr_pkg::DROP_NONE;
    priority if (pos_r == '0) begin
      start_nxt = data;
      pos_nxt   = sfr_pkg::POS_W'(1);
    end else if (pos_r == sfr_pkg::POS_W'(1)) begin
      if (start_r != sfr_pkg::START_BYTE) begin
        res.drop_code = sfr_pkg::DROP_START;
        pos_nxt       = '0;
      end else begin
        len_nxt = data;
        crc_nxt = crc_start;
        pos_nxt = sfr_pkg::POS_W'(2);
      end
    end else if (pos_r == sfr_pkg::POS_W'(sfr_pkg::FRAME_STORE_BYTES - 1)) begin
      res.drop_code = sfr_pkg::DROP_FRAME;
      pos_nxt       = '0;
    end else if (pos_ext < len_ext + sfr_pkg::CMP_W'(2)) begin
      res.payload_byte  = data;
      res.payload_valid = 1'b1;
      res.payload_index = 8'(pos_ext - sfr_pkg::CMP_W'(2));
      crc_nxt = crc_upd;
      pos_nxt = pos_r + 1'b1;
    end else if (pos_ext == len_ext + sfr_pkg::CMP_W'(2)) begin
      rx_hi_nxt = data;
      pos_nxt   = pos_r + 1'b1;
    end else if (pos_ext == len_ext + sfr_pkg::CMP_W'(3)) begin
      rx_lo_nxt = data;
      pos_nxt   = pos_r + 1'b1;
    end else begin
      if (data == sfr_pkg::END_BYTE) begin
        res.frame_done   = 1'b1;
        res.crc_ok       = (crc_r == {rx_hi_r, rx_lo_r});
        res.frame_length = len_r;
      end else begin
        res.drop_code = sfr_pkg::DROP_FRAME;
      end
      pos_nxt = '0;
    end
  end

  assign st.hunting = (pos_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      rx_hi_r <= rx_hi_nxt;
      rx_lo_r <= rx_lo_nxt;
    end
  end

endmodule
